FILE: rtl/hrrn_pkg.sv
// shared constants, slot record, memory request and state types for the hrrn scheduler
package hrrn_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W   = 5;
  localparam int ID_W        = 8;
  localparam int TIME_W      = 32;
  localparam int LEFT_W      = 16;
  localparam int SEQ_W       = 32;
  localparam int WAIT_W      = TIME_W + 1;
  localparam int DEN_W       = LEFT_W + 1;
  localparam int PROD_W      = WAIT_W + DEN_W;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ARRIVAL = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [LEFT_W-1:0] left;
    logic [SEQ_W-1:0]  seq;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/hrrn_in_if.sv
// input beat channel of the hrrn scheduler
interface hrrn_in_if import hrrn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ID_W-1:0]   proc_id;
  logic [TIME_W-1:0] arrival_time;
  logic [LEFT_W-1:0] burst_length;

  modport source (output valid, output cmd, output proc_id, output arrival_time,
                  output burst_length, input ready);
  modport sink (input valid, input cmd, input proc_id, input arrival_time,
                input burst_length, output ready);
endinterface

FILE: rtl/hrrn_out_if.sv
// result beat channel of the hrrn scheduler
interface hrrn_out_if import hrrn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 running_valid;
  logic [ID_W-1:0]      running_id;
  logic [LEFT_W-1:0]    remaining_time;
  logic                 arrival_dropped;
  logic [OUT_CNT_W-1:0] queued_count;

  modport source (output valid, output running_valid, output running_id,
                  output remaining_time, output arrival_dropped, output queued_count,
                  input ready);
  modport sink (input valid, input running_valid, input running_id,
                input remaining_time, input arrival_dropped, input queued_count,
                output ready);
endinterface

FILE: rtl/hrrn_slot_ram.sv
// ready queue slot memory, one write and one registered read port
module hrrn_slot_ram import hrrn_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output slot_t    rdata
);

  slot_t mem [QUEUE_DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hrrn_rank.sv
// response ratio compare: registered cross products, then compare with age tie break
module hrrn_rank import hrrn_pkg::*; (
  input  logic              clk,
  input  slot_t             cand,
  input  slot_t             best,
  input  logic [TIME_W-1:0] now,
  input  logic [SEQ_W-1:0]  next_seq,
  output logic              above
);

  logic signed [WAIT_W-1:0] wait_c;
  logic signed [WAIT_W-1:0] wait_b;
  logic signed [DEN_W-1:0]  den_c;
  logic signed [DEN_W-1:0]  den_b;
  logic signed [PROD_W-1:0] lhs_nxt;
  logic signed [PROD_W-1:0] rhs_nxt;
  logic signed [PROD_W-1:0] lhs_r;
  logic signed [PROD_W-1:0] rhs_r;
  logic [SEQ_W-1:0]         age_c_r;
  logic [SEQ_W-1:0]         age_b_r;

  always_comb begin
    wait_c  = $signed({1'b0, now}) - $signed({1'b0, cand.start});
    wait_b  = $signed({1'b0, now}) - $signed({1'b0, best.start});
    den_c   = $signed({1'b0, (cand.left == '0) ? LEFT_W'(1) : cand.left});
    den_b   = $signed({1'b0, (best.left == '0) ? LEFT_W'(1) : best.left});
    lhs_nxt = wait_c * den_b;
    rhs_nxt = wait_b * den_c;
  end

  always_ff @(posedge clk) begin
    lhs_r   <= lhs_nxt;
    rhs_r   <= rhs_nxt;
    age_c_r <= next_seq - cand.seq;
    age_b_r <= next_seq - best.seq;
  end

  assign above = (lhs_r > rhs_r) || ((lhs_r == rhs_r) && (age_c_r > age_b_r));

endmodule

FILE: rtl/hrrn_process_scheduler.sv
// top level of the highest response ratio next process scheduler
// Non-preemptive highest-response-ratio-next scheduler. Every input beat gives
// exactly one result beat. An arrival, and a tick that leaves the running process
// in place, go straight from acceptance to the emit state. A tick that must pick a
// new process walks all queue slots through the slot memory, in a multiply state
// and a compare state per slot (the registered cross-multiply, then the ratio
// compare overlapped with the next memory read), then finishes the pick before
// emitting. One beat is worked on at a time; a new beat is accepted while an
// earlier result is still waiting in the output register.
module hrrn_process_scheduler import hrrn_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  hrrn_in_if.sink   in_ch,
  hrrn_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]      time_r;
  logic                   run_valid_r;
  logic [ID_W-1:0]        run_id_r;
  logic [LEFT_W-1:0]      run_left_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [SEQ_W-1:0]       next_seq_r;
  logic                   dropped_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   found_r;
  slot_t                  best_r;
  logic [IDX_W-1:0]       best_idx_r;

  logic                   out_valid_r;
  logic                   out_run_valid_r;
  logic [ID_W-1:0]        out_id_r;
  logic [LEFT_W-1:0]      out_left_r;
  logic                   out_dropped_r;
  logic [OUT_CNT_W-1:0]   out_count_r;

  logic             in_fire;
  logic             need_pick;
  logic             last_slot;
  logic             take;
  logic             emit_ok;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  ram_req_t         ram_req;
  slot_t            rdata;
  logic             above;

  hrrn_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  hrrn_rank u_rank (
    .clk      (clk),
    .cand     (rdata),
    .best     (best_r),
    .now      (time_r),
    .next_seq (next_seq_r),
    .above    (above)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign need_pick = !run_valid_r || (run_left_r == '0);
  assign last_slot = (idx_r == IDX_W'(QUEUE_DEPTH - 1));
  assign take      = valid_r[idx_r] && (!found_r || above);
  assign emit_ok   = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_ch.cmd == CMD_TICK) && need_pick) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL:    state_nxt = ST_CMP;
      ST_CMP:    state_nxt = last_slot ? ST_FINISH : ST_MUL;
      ST_FINISH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready   = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = free_idx;
    ram_req.wdata = '{id: in_ch.proc_id, start: in_ch.arrival_time,
                      left: in_ch.burst_length, seq: next_seq_r};
    ram_req.re    = 1'b0;
    ram_req.raddr = '0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_req.we  = in_fire && (in_ch.cmd == CMD_ARRIVAL) && run_valid_r && free_found;
        ram_req.re  = in_fire && (in_ch.cmd == CMD_TICK);
      end
      ST_CMP: begin
        ram_req.re    = !last_slot;
        ram_req.raddr = idx_r + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_left_r  <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      next_seq_r  <= '0;
      dropped_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            dropped_r <= 1'b0;
            idx_r     <= '0;
            found_r   <= 1'b0;
            if (in_ch.cmd == CMD_ARRIVAL) begin
              if (!run_valid_r) begin
                run_valid_r <= 1'b1;
                run_id_r    <= in_ch.proc_id;
                run_left_r  <= in_ch.burst_length;
              end else if (free_found) begin
                valid_r[free_idx] <= 1'b1;
                count_r           <= count_r + CNT_W'(1);
                next_seq_r        <= next_seq_r + SEQ_W'(1);
              end else begin
                dropped_r <= 1'b1;
              end
            end else begin
              time_r <= time_r + TIME_W'(1);
              if (!need_pick) begin
                run_left_r <= run_left_r - LEFT_W'(1);
              end
            end
          end
        end
        ST_CMP: begin
          if (take) begin
            best_r     <= rdata;
            best_idx_r <= idx_r;
            found_r    <= 1'b1;
          end
          if (!last_slot) begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (found_r) begin
            valid_r[best_idx_r] <= 1'b0;
            count_r             <= count_r - CNT_W'(1);
            run_valid_r         <= 1'b1;
            run_id_r            <= best_r.id;
            run_left_r          <= (best_r.left == '0) ? '0 : best_r.left - LEFT_W'(1);
          end else begin
            run_valid_r <= 1'b0;
            run_id_r    <= '0;
            run_left_r  <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_r     <= 1'b1;
            out_run_valid_r <= run_valid_r;
            out_id_r        <= run_valid_r ? run_id_r : '0;
            out_left_r      <= run_valid_r ? run_left_r : '0;
            out_dropped_r   <= dropped_r;
            out_count_r     <= OUT_CNT_W'(count_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.running_valid   = out_run_valid_r;
  assign out_ch.running_id      = out_id_r;
  assign out_ch.remaining_time  = out_left_r;
  assign out_ch.arrival_dropped = out_dropped_r;
  assign out_ch.queued_count    = out_count_r;

endmodule

FILE: bench/hrrn_process_scheduler_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the hrrn process scheduler: directed table, then random beats
module hrrn_process_scheduler_test;
  import hrrn_pkg::*;

  localparam int DIR_ROWS     = 24;
  localparam int RANDOM_ITEMS = 1926;
  localparam int PHASES       = 3;
  localparam int SEGMENT      = 40;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 30;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrival_time;
    logic [LEFT_W-1:0] burst_length;
  } sched_beat_t;

  typedef struct packed {
    logic                 running_valid;
    logic [ID_W-1:0]      running_id;
    logic [LEFT_W-1:0]    remaining_time;
    logic                 arrival_dropped;
    logic [OUT_CNT_W-1:0] queued_count;
  } sched_result_t;

  typedef struct packed {
    sched_beat_t   beat;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  localparam sched_result_t UNTYPED = '0;

  // fill the queue behind a zero-burst runner, ties and future starts, then one drop and five ticks
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {CMD_TICK,    8'h00, 32'h0000_0000, 16'h0000, 1'b1, {1'b0, 8'h00, 16'h0000, 1'b0, 5'd0}},
    {CMD_ARRIVAL, 8'h00, 32'h0000_0000, 16'h0000, 1'b1, {1'b1, 8'h00, 16'h0000, 1'b0, 5'd0}},
    {CMD_ARRIVAL, 8'hff, 32'hffff_ffff, 16'h0003, 1'b1, {1'b1, 8'h00, 16'h0000, 1'b0, 5'd1}},
    {CMD_ARRIVAL, 8'h01, 32'h0000_0000, 16'h0001, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h02, 32'h0000_0000, 16'h0000, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h03, 32'h0000_0000, 16'h0001, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h04, 32'h0000_0001, 16'h0001, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h05, 32'h0000_0002, 16'h0002, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h06, 32'haaaa_aaaa, 16'h0005, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h07, 32'h5555_5555, 16'h0004, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h08, 32'h0000_0000, 16'h0007, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h09, 32'h0000_0001, 16'h0003, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0a, 32'h0000_0000, 16'h0002, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0b, 32'h0000_0000, 16'h0009, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0c, 32'h0000_0001, 16'h0006, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0d, 32'h0000_0000, 16'h0004, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0e, 32'h0000_0000, 16'h0001, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h0f, 32'h0000_0000, 16'h0008, 1'b0, UNTYPED},
    {CMD_ARRIVAL, 8'h80, 32'h7fff_ffff, 16'hffff, 1'b1, {1'b1, 8'h00, 16'h0000, 1'b1, 5'd16}},
    {CMD_TICK,    8'hff, 32'hffff_ffff, 16'hffff, 1'b0, UNTYPED},
    {CMD_TICK,    8'h00, 32'h0000_0000, 16'h0000, 1'b0, UNTYPED},
    {CMD_TICK,    8'h00, 32'h0000_0000, 16'h0000, 1'b0, UNTYPED},
    {CMD_TICK,    8'h00, 32'h0000_0000, 16'h0000, 1'b0, UNTYPED},
    {CMD_TICK,    8'h00, 32'h0000_0000, 16'h0000, 1'b0, UNTYPED}
  };

  logic clk;
  logic rst_n;

  hrrn_in_if  in_if ();
  hrrn_out_if out_if ();

  hrrn_process_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // scheduler image kept alongside the block
  logic [TIME_W-1:0] now_tick;
  logic              busy;
  logic [ID_W-1:0]   busy_id;
  logic [LEFT_W-1:0] busy_left;
  logic              waiting    [QUEUE_DEPTH];
  logic [ID_W-1:0]   wait_id    [QUEUE_DEPTH];
  logic [TIME_W-1:0] wait_start [QUEUE_DEPTH];
  logic [LEFT_W-1:0] wait_left  [QUEUE_DEPTH];
  logic [SEQ_W-1:0]  wait_seq   [QUEUE_DEPTH];
  logic [SEQ_W-1:0]  seq_next;

  sched_result_t pending_results [$];

  int sender_gap_pct;
  int recv_stall_pct;
  int beats_sent;
  int ticks_sent;
  int arrivals_sent;
  int drops_seen;
  int results_checked;
  int failures;
  int reports;
  int cycles;

  function automatic int queued_now();
    int n;
    n = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (waiting[i]) n++;
    end
    return n;
  endfunction

  // exact ratio compare: wait_a / den_a against wait_b / den_b, oldest wins a tie
  function automatic logic outranks(int a, int b);
    longint           wait_a;
    longint           wait_b;
    longint           den_a;
    longint           den_b;
    logic [SEQ_W-1:0] age_a;
    logic [SEQ_W-1:0] age_b;
    wait_a = longint'(now_tick) - longint'(wait_start[a]);
    wait_b = longint'(now_tick) - longint'(wait_start[b]);
    den_a = (wait_left[a] == '0) ? 64'd1 : 64'(wait_left[a]);
    den_b = (wait_left[b] == '0) ? 64'd1 : 64'(wait_left[b]);
    if (wait_a * den_b != wait_b * den_a) return wait_a * den_b > wait_b * den_a;
    age_a = seq_next - wait_seq[a];
    age_b = seq_next - wait_seq[b];
    return age_a > age_b;
  endfunction

  function automatic sched_result_t schedule_step(sched_beat_t b);
    sched_result_t r;
    logic          dropped;
    logic          placed;
    int            best;
    dropped = 1'b0;
    if (b.cmd == CMD_ARRIVAL) begin
      if (!busy) begin
        busy      = 1'b1;
        busy_id   = b.proc_id;
        busy_left = b.burst_length;
      end else begin
        placed = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!placed && !waiting[i]) begin
            waiting[i]    = 1'b1;
            wait_id[i]    = b.proc_id;
            wait_start[i] = b.arrival_time;
            wait_left[i]  = b.burst_length;
            wait_seq[i]   = seq_next;
            seq_next      = seq_next + 1'b1;
            placed        = 1'b1;
          end
        end
        dropped = !placed;
      end
    end else begin
      now_tick = now_tick + 1'b1;
      if (!busy || busy_left == '0) begin
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (waiting[i] && (best < 0 || outranks(i, best))) best = i;
        end
        if (best >= 0) begin
          waiting[best] = 1'b0;
          busy          = 1'b1;
          busy_id       = wait_id[best];
          busy_left     = wait_left[best];
        end else begin
          busy      = 1'b0;
          busy_id   = '0;
          busy_left = '0;
        end
      end
      if (busy && busy_left != '0) busy_left = busy_left - 1'b1;
    end
    r.running_valid   = busy;
    r.running_id      = busy ? busy_id : '0;
    r.remaining_time  = busy ? busy_left : '0;
    r.arrival_dropped = dropped;
    r.queued_count    = OUT_CNT_W'(queued_now());
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input sched_beat_t b, input logic typed, input sched_result_t want);
    sched_result_t predicted;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= b.cmd;
    in_if.proc_id      <= b.proc_id;
    in_if.arrival_time <= b.arrival_time;
    in_if.burst_length <= b.burst_length;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = schedule_step(b);
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
    if (b.cmd == CMD_TICK) ticks_sent++;
    else arrivals_sent++;
    if (predicted.arrival_dropped) drops_seen++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    sched_result_t oldest;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t unexpected result beat: valid=%0d id=%0d left=%0d drop=%0d count=%0d",
                   $time, out_if.running_valid, out_if.running_id, out_if.remaining_time,
                   out_if.arrival_dropped, out_if.queued_count);
        end
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (out_if.running_valid !== oldest.running_valid ||
            out_if.running_id !== oldest.running_id ||
            out_if.remaining_time !== oldest.remaining_time ||
            out_if.arrival_dropped !== oldest.arrival_dropped ||
            out_if.queued_count !== oldest.queued_count) begin
          failures++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t mismatch: expected valid=%0d id=%0d left=%0d drop=%0d count=%0d",
                     $time, oldest.running_valid, oldest.running_id, oldest.remaining_time,
                     oldest.arrival_dropped, oldest.queued_count);
            $display("%0t            actual valid=%0d id=%0d left=%0d drop=%0d count=%0d",
                     $time, out_if.running_valid, out_if.running_id, out_if.remaining_time,
                     out_if.arrival_dropped, out_if.queued_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sched_beat_t beat;
    int          tick_pct;
    int          pick;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_TICK;
    in_if.proc_id      = '0;
    in_if.arrival_time = '0;
    in_if.burst_length = '0;
    out_if.ready       = 1'b0;
    sender_gap_pct     = 7;
    recv_stall_pct     = 49;
    beats_sent         = 0;
    ticks_sent         = 0;
    arrivals_sent      = 0;
    drops_seen         = 0;
    results_checked    = 0;
    failures           = 0;
    reports            = 0;
    cycles             = 0;
    tick_pct           = 55;
    now_tick           = '0;
    busy               = 1'b0;
    busy_id            = '0;
    busy_left          = '0;
    seq_next           = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) waiting[i] = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_beat(DIRECTED[r].beat, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sender_gap_pct = 7;
          recv_stall_pct = 49;
        end
        1: begin
          sender_gap_pct = 49;
          recv_stall_pct = 7;
        end
        default: begin
          sender_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        if (k % SEGMENT == 0) begin
          case ($urandom_range(0, 2))
            0: tick_pct = 25;
            1: tick_pct = 55;
            default: tick_pct = 85;
          endcase
        end
        beat.cmd          = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_ARRIVAL;
        beat.proc_id      = ID_W'($urandom);
        beat.arrival_time = $urandom;
        beat.burst_length = LEFT_W'($urandom_range(1, 65535));
        // arrivals that will be kept mostly get short bursts and starts near the clock
        if (beat.cmd == CMD_ARRIVAL && !(busy && queued_now() == QUEUE_DEPTH)) begin
          pick = $urandom_range(0, 99);
          if (pick < 78) beat.burst_length = LEFT_W'($urandom_range(1, 4));
          else if (pick < 98) beat.burst_length = LEFT_W'($urandom_range(5, 32));
          else beat.burst_length = LEFT_W'($urandom_range(64, 400));
          pick = $urandom_range(0, 99);
          if (pick < 70) beat.arrival_time = now_tick - $urandom_range(0, 30);
          else if (pick < 85) beat.arrival_time = now_tick + $urandom_range(1, 30);
        end
        send_beat(beat, 1'b0, UNTYPED);
      end
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d beats driven: %0d ticks, %0d arrivals of which %0d hit a full queue",
             beats_sent, ticks_sent, arrivals_sent, drops_seen);
    $display("%0d result beats compared across three handshake pressure phases, %0d failures",
             results_checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
